// ===== hdl/fog_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fog pixel effect package
// Widths, scaled constants and shared types for the fog pixel datapath.
// ----------------------------------------------------------------------------
package fog_pkg;

  localparam int unsigned FOG_FRAC_BITS = 8;
  localparam int unsigned FOG_W         = 9;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned NUM_CHAN      = 3;
  localparam int unsigned DATA_W        = NUM_CHAN * CHAN_W;
  localparam int unsigned SUM_W         = CHAN_W + 2;
  localparam int unsigned FSQ_W         = 2 * FOG_W;
  localparam int unsigned CFG_ADDR_W    = 1;

  // All terms are scaled by 1 / (500 * 2^(2*FOG_FRAC_BITS)).
  localparam longint unsigned SCALE      = 64'd1 << FOG_FRAC_BITS;
  localparam longint unsigned UNIT       = 64'd500 * SCALE;
  localparam longint unsigned DEN        = UNIT * SCALE;
  localparam longint unsigned BASE_GAIN  = 64'd750 * SCALE * SCALE;
  localparam longint unsigned FOG_MAX    = 64'd511;

  localparam longint unsigned HI_GAIN_K  = UNIT;
  localparam longint unsigned LO_GAIN_K  = 64'd500;
  localparam longint unsigned MID_GAIN_K = 64'd707;
  localparam longint unsigned HI_OFFS_K  = 64'd7 * UNIT;
  localparam longint unsigned LO_OFFS_K  = 64'd130 * UNIT;
  localparam longint unsigned MID_OFFS_K = 64'd100 * UNIT;
  localparam longint unsigned MID_EXTRA  = 64'd20 * DEN;
  localparam longint unsigned TILT_K     = 64'd4 * UNIT;

  localparam longint unsigned GAIN_MAX =
    BASE_GAIN + MID_GAIN_K * FOG_MAX * FOG_MAX + HI_GAIN_K * FOG_MAX;
  localparam longint unsigned OFFS_MAX =
    (LO_OFFS_K + TILT_K) * FOG_MAX + MID_EXTRA;
  localparam longint unsigned V_MAX    = 64'd255 * GAIN_MAX + OFFS_MAX;

  localparam int unsigned GAIN_W   = $clog2(GAIN_MAX + 64'd1);
  localparam int unsigned OFFS_W   = $clog2(OFFS_MAX + 64'd1);
  localparam int unsigned V_W      = $clog2(V_MAX + 64'd1);
  localparam int unsigned WF_W     = V_W - 2 * FOG_FRAC_BITS;

  // Quotient by 500 through a reciprocal, exact below the saturation limit.
  localparam longint unsigned SAT_LIM     = 64'd128000;
  localparam int unsigned     Q_W         = 17;
  localparam longint unsigned RECIP       = 64'd134218;
  localparam int unsigned     RECIP_W     = 18;
  localparam int unsigned     RECIP_SHIFT = 26;
  localparam int unsigned     PROD_W      = Q_W + RECIP_W;

  localparam int unsigned LIM_BRIGHT = 240;
  localparam int unsigned LIM_HIGH   = 170;
  localparam int unsigned LIM_LOW    = 85;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FOG_LEVEL     = 1'b0,
    REG_THREE_CHANNEL = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } band_e;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

endpackage
`default_nettype wire

// ===== hdl/fog_pixel_effect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fog pixel effect
// Applies a brightness-banded gain and offset to each pixel, clamped to 8 bits.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, unless a stalled output backs up into the input, and
// returns the fogged pixels in order. After the input register, each stage is one
// step of the arithmetic: brightness band and fog square, gain and offset forming,
// one multiply-add per channel, and the final scale by reciprocal with saturation.
// Stages hold independently, so a stalled output still lets empty stages fill.
// Configuration is sampled with each pixel at input.
module fog_pixel_effect
  import fog_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire [FOG_W-1:0]      cfg_wdata_i,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire [DATA_W-1:0]     s_axis_tdata_i,  // chan0_in, chan1_in, chan2_in
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [DATA_W-1:0]    m_axis_tdata_o   // chan0_out, chan1_out, chan2_out
);

  logic [FOG_W-1:0] fog_q;
  logic             tri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fog_q <= '0;
      tri_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_FOG_LEVEL:     fog_q <= cfg_wdata_i;
        REG_THREE_CHANNEL: tri_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage valid and enable chain
  logic [4:0] vld_q, vld_d, en;

  always_comb begin
    en[4] = !vld_q[4] || m_axis_tready_i;
    en[3] = !vld_q[3] || en[4];
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
    en[0] = !vld_q[0] || en[1];
    vld_d = vld_q;
    if (en[0]) vld_d[0] = s_axis_tvalid_i;
    if (en[1]) vld_d[1] = vld_q[0];
    if (en[2]) vld_d[2] = vld_q[1];
    if (en[3]) vld_d[3] = vld_q[2];
    if (en[4]) vld_d[4] = vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[4];

  // Stage 1: input register
  pix_t             s1_pix_q;
  logic [FOG_W-1:0] s1_fog_q;
  logic             s1_tri_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_pix_q <= s_axis_tdata_i;
      s1_fog_q <= fog_q;
      s1_tri_q <= tri_q;
    end
  end

  // Stage 1 -> 2: brightness band, bypass, fog square
  logic [SUM_W-1:0] bright;
  logic [SUM_W-1:0] lim_bright, lim_high, lim_low;
  logic             s2_pass_d;
  band_e            s2_band_d;

  always_comb begin
    if (s1_tri_q) begin
      bright     = SUM_W'(s1_pix_q[0]) + SUM_W'(s1_pix_q[1]) + SUM_W'(s1_pix_q[2]);
      lim_bright = SUM_W'(3 * LIM_BRIGHT);
      lim_high   = SUM_W'(3 * LIM_HIGH);
      lim_low    = SUM_W'(3 * LIM_LOW);
    end else begin
      bright     = SUM_W'(s1_pix_q[0]);
      lim_bright = SUM_W'(LIM_BRIGHT);
      lim_high   = SUM_W'(LIM_HIGH);
      lim_low    = SUM_W'(LIM_LOW);
    end
    s2_pass_d = (s1_fog_q == '0) || (bright >= lim_bright);
    if (bright >= lim_high) begin
      s2_band_d = BAND_HIGH;
    end else if (bright <= lim_low) begin
      s2_band_d = BAND_LOW;
    end else begin
      s2_band_d = BAND_MID;
    end
  end

  pix_t             s2_pix_q;
  logic [FOG_W-1:0] s2_fog_q;
  logic [FSQ_W-1:0] s2_fsq_q;
  logic             s2_tri_q;
  logic             s2_pass_q;
  band_e            s2_band_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_pix_q  <= s1_pix_q;
      s2_fog_q  <= s1_fog_q;
      s2_fsq_q  <= FSQ_W'(s1_fog_q) * FSQ_W'(s1_fog_q);
      s2_tri_q  <= s1_tri_q;
      s2_pass_q <= s2_pass_d;
      s2_band_q <= s2_band_d;
    end
  end

  // Stage 2 -> 3: gain and per-channel offsets
  logic [GAIN_W-1:0]              gain_d;
  logic [OFFS_W-1:0]              offs_com, offs_ext, tilt;
  logic [NUM_CHAN-1:0][OFFS_W-1:0] offs_d;

  always_comb begin
    tilt     = OFFS_W'(s2_fog_q) * OFFS_W'(TILT_K);
    offs_ext = '0;
    case (s2_band_q)
      BAND_HIGH: begin
        gain_d   = GAIN_W'(BASE_GAIN) + GAIN_W'(s2_fog_q) * GAIN_W'(HI_GAIN_K);
        offs_com = OFFS_W'(s2_fog_q) * OFFS_W'(HI_OFFS_K);
      end
      BAND_LOW: begin
        gain_d   = GAIN_W'(BASE_GAIN) + GAIN_W'(s2_fsq_q) * GAIN_W'(LO_GAIN_K);
        offs_com = OFFS_W'(s2_fog_q) * OFFS_W'(LO_OFFS_K);
      end
      default: begin
        gain_d   = GAIN_W'(BASE_GAIN) + GAIN_W'(s2_fsq_q) * GAIN_W'(MID_GAIN_K);
        offs_com = OFFS_W'(s2_fog_q) * OFFS_W'(MID_OFFS_K);
        offs_ext = OFFS_W'(MID_EXTRA);
      end
    endcase
    offs_d[0] = offs_com + offs_ext - tilt;
    offs_d[1] = offs_com + offs_ext;
    offs_d[2] = offs_com + tilt;
  end

  pix_t                            s3_pix_q;
  logic [GAIN_W-1:0]               s3_gain_q;
  logic [NUM_CHAN-1:0][OFFS_W-1:0] s3_offs_q;
  logic [NUM_CHAN-1:0]             s3_pass_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_pix_q     <= s2_pix_q;
      s3_gain_q    <= gain_d;
      s3_offs_q    <= offs_d;
      s3_pass_q[0] <= s2_pass_q;
      s3_pass_q[1] <= s2_pass_q || !s2_tri_q;
      s3_pass_q[2] <= s2_pass_q || !s2_tri_q;
    end
  end

  // Stage 3 -> 4: multiply-add per channel
  logic [NUM_CHAN-1:0][V_W-1:0] val_d;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      val_d[c] = V_W'(s3_pix_q[c]) * V_W'(s3_gain_q) + V_W'(s3_offs_q[c]);
    end
  end

  pix_t                         s4_pix_q;
  logic [NUM_CHAN-1:0][V_W-1:0] s4_val_q;
  logic [NUM_CHAN-1:0]          s4_pass_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_pix_q  <= s3_pix_q;
      s4_val_q  <= val_d;
      s4_pass_q <= s3_pass_q;
    end
  end

  // Stage 4 -> 5: scale down, saturate, select bypass
  logic [NUM_CHAN-1:0][WF_W-1:0]   wfull;
  logic [NUM_CHAN-1:0][PROD_W-1:0] prod;
  pix_t                            res_d;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      wfull[c] = s4_val_q[c][V_W-1:2*FOG_FRAC_BITS];
      prod[c]  = PROD_W'(wfull[c][Q_W-1:0]) * PROD_W'(RECIP);
      if (s4_pass_q[c]) begin
        res_d[c] = s4_pix_q[c];
      end else if (wfull[c] >= WF_W'(SAT_LIM)) begin
        res_d[c] = '1;
      end else begin
        res_d[c] = prod[c][RECIP_SHIFT +: CHAN_W];
      end
    end
  end

  pix_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule
`default_nettype wire

// ===== dv/fog_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fog pixel effect checker
// Watches the register port and both streams, predicts each fogged pixel from
// the register values in force when it was accepted, and compares the output
// stream channel by channel in order.
// ----------------------------------------------------------------------------
module fog_pixel_checker
  import fog_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire [FOG_W-1:0]      cfg_wdata_i,
  input  wire                  s_tvalid_i,
  input  wire                  s_tready_i,
  input  wire [DATA_W-1:0]     s_tdata_i,  // chan0_in, chan1_in, chan2_in
  input  wire                  m_tvalid_i,
  input  wire                  m_tready_i,
  input  wire [DATA_W-1:0]     m_tdata_i,  // chan0_out, chan1_out, chan2_out
  output int                   fail_cnt_o,
  output int                   pending_o
);

  logic [FOG_W-1:0] fog_lvl  = '0;
  logic             three_ch = 1'b1;
  pix_t             fogged_q[$];
  int               fail_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_cnt = fail_cnt + 1;
  endtask

  // x * gain + offset over the common denominator, clamped to 0..255
  function automatic logic [CHAN_W-1:0] fog_clamp(input logic [CHAN_W-1:0] x,
                                                  input longint gain,
                                                  input longint offs,
                                                  input longint den);
    longint v;
    longint q;
    v = longint'(x) * gain + offs;
    if (v < 0) begin
      return '0;
    end
    q = v / den;
    if (q > 255) begin
      q = 255;
    end
    return q[CHAN_W-1:0];
  endfunction

  // Terms kept as integers over 2000 * 2^(2*FOG_FRAC_BITS), so nothing rounds
  // before the final divide.
  function automatic pix_t fog_predict(input pix_t px, input logic [FOG_W-1:0] fog,
                                       input logic tri_mode);
    longint f;
    longint br;
    longint k;
    longint s;
    longint unit;
    longint den;
    longint base;
    longint gain;
    longint offs;
    longint bump;
    band_e  band;
    pix_t   res;
    res = px;
    f   = longint'(fog);
    if (f == 0) begin
      return res;
    end
    if (tri_mode) begin
      br = longint'(px[0]) + longint'(px[1]) + longint'(px[2]);
      k  = 3;
    end else begin
      br = longint'(px[0]);
      k  = 1;
    end
    if (br >= longint'(LIM_BRIGHT) * k) begin
      return res;
    end
    s    = longint'(1) << FOG_FRAC_BITS;
    unit = 2000 * s;
    den  = unit * s;
    base = 3000 * s * s;
    bump = 0;
    if (br >= longint'(LIM_HIGH) * k) begin
      band = BAND_HIGH;
    end else if (br <= longint'(LIM_LOW) * k) begin
      band = BAND_LOW;
    end else begin
      band = BAND_MID;
    end
    case (band)
      BAND_HIGH: begin
        gain = base + f * unit;
        offs = 7 * f * unit;
      end
      BAND_LOW: begin
        gain = base + f * f * 2000;
        offs = 130 * f * unit;
      end
      default: begin
        gain = base + f * f * 2828;
        offs = 100 * f * unit;
        bump = 20 * den;
      end
    endcase
    res[0] = fog_clamp(px[0], gain, offs - 4 * f * unit + bump, den);
    if (tri_mode) begin
      res[1] = fog_clamp(px[1], gain, offs + bump, den);
      res[2] = fog_clamp(px[2], gain, offs + 4 * f * unit, den);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    pix_t want;
    pix_t got;
    if (!rst_ni) begin
      fog_lvl  = '0;
      three_ch = 1'b1;
    end else begin
      // pixel uses the registers in force before any write on this edge
      if (s_tvalid_i && s_tready_i) begin
        fogged_q.push_back(fog_predict(pix_t'(s_tdata_i), fog_lvl, three_ch));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = pix_t'(m_tdata_i);
        if (fogged_q.size() == 0) begin
          report_mismatch($sformatf("output transaction %h with no pixel waiting", got));
        end else begin
          want = fogged_q.pop_front();
          for (int c = 0; c < NUM_CHAN; c++) begin
            if (got[c] !== want[c]) begin
              report_mismatch($sformatf("chan%0d_out got %0d want %0d (fog %0d, tri %0b)",
                                        c, got[c], want[c], fog_lvl, three_ch));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_FOG_LEVEL:     fog_lvl  = cfg_wdata_i;
          REG_THREE_CHANNEL: three_ch = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    pending_o  <= fogged_q.size();
    fail_cnt_o <= fail_cnt;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fog pixel effect testbench
// Drives pixel bursts through the fog block under a series of fog levels and
// channel modes, with random sender gaps and receiver stalls; the checker
// beside the block predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import fog_pkg::*;

  localparam int NUM_PHASES      = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LIMIT_CYCLES    = 400000;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_e;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [FOG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [DATA_W-1:0]     m_tdata;
  int                    fail_cnt;
  int                    pending;

  rx_mode_e rx_mode = RX_COIN;
  int       rx_step = 0;
  int       rx_hold = 0;

  fog_pixel_effect dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  fog_pixel_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  always @(negedge clk) begin
    rx_step = rx_step + 1;
    case (rx_mode)
      RX_OPEN: m_tready <= 1'b1;
      RX_COIN: m_tready <= 1'($urandom_range(0, 1));
      RX_COMB: m_tready <= (rx_step % 5 != 2) && (rx_step % 7 != 3);
      default: begin
        if (rx_hold > 0) begin
          rx_hold = rx_hold - 1;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(4, 16);
          end
        end
      end
    endcase
  end

  function automatic pix_t pixel_of(input int c0, input int c1, input int c2);
    pix_t px;
    px[0] = c0[CHAN_W-1:0];
    px[1] = c1[CHAN_W-1:0];
    px[2] = c2[CHAN_W-1:0];
    return px;
  endfunction

  function automatic int sat8(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // mix of uniform, grey-ish, near band edges and extreme pixels
  function automatic pix_t random_pixel();
    int kind;
    int lvl;
    int edges[3];
    kind     = $urandom_range(0, 9);
    edges[0] = LIM_LOW;
    edges[1] = LIM_HIGH;
    edges[2] = LIM_BRIGHT;
    if (kind <= 3) begin
      return pixel_of($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (kind <= 6) begin
      lvl = $urandom_range(0, 255);
      return pixel_of(sat8(lvl + $urandom_range(0, 16) - 8), sat8(lvl + $urandom_range(0, 16) - 8),
                      sat8(lvl + $urandom_range(0, 16) - 8));
    end else if (kind <= 8) begin
      lvl = edges[$urandom_range(0, 2)] + $urandom_range(0, 4) - 2;
      return pixel_of(sat8(lvl + $urandom_range(0, 2) - 1), sat8(lvl + $urandom_range(0, 2) - 1),
                      sat8(lvl + $urandom_range(0, 2) - 1));
    end
    return pixel_of($urandom_range(0, 1) * 255, $urandom_range(0, 2) == 0 ? 0 : 255,
                    $urandom_range(0, 255));
  endfunction

  task automatic push_pixel(input pix_t px, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[FOG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    pix_t pix_list[$];
    int   fog_pick[8];
    int   burst_left;
    int   gap_max;
    int   gap;
    int   fog;
    fog_pick   = '{1, 1, 511, 511, 0, 0, 256, 255};
    burst_left = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: zero fog passes everything through
    pix_list = '{pixel_of(0, 0, 0), pixel_of(255, 255, 255), pixel_of(100, 50, 200)};
    foreach (pix_list[i]) push_pixel(pix_list[i], $urandom_range(0, 2));

    wait_drained();
    rx_mode = RX_CHOKE;
    write_reg(REG_FOG_LEVEL, 256);
    write_reg(REG_THREE_CHANNEL, 1);
    pix_list = '{pixel_of(240, 240, 240), pixel_of(240, 240, 239), pixel_of(170, 170, 170),
                 pixel_of(170, 170, 169), pixel_of(85, 85, 85), pixel_of(86, 85, 85),
                 pixel_of(0, 0, 0), pixel_of(255, 0, 0), pixel_of(0, 255, 255),
                 pixel_of(10, 200, 30)};
    foreach (pix_list[i]) push_pixel(pix_list[i], $urandom_range(0, 2));

    // single channel, fog above 1.0
    wait_drained();
    rx_mode = RX_COMB;
    write_reg(REG_FOG_LEVEL, 300);
    write_reg(REG_THREE_CHANNEL, 0);
    pix_list = '{pixel_of(240, 0, 0), pixel_of(239, 255, 255), pixel_of(170, 0, 255),
                 pixel_of(169, 255, 0), pixel_of(85, 12, 34), pixel_of(86, 255, 255),
                 pixel_of(0, 255, 255), pixel_of(255, 0, 0)};
    foreach (pix_list[i]) push_pixel(pix_list[i], $urandom_range(0, 2));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      rx_mode = rx_mode_e'(p % 4);
      gap_max = (p % 4 == 0) ? 0 : (p % 3 == 0) ? 12 : 6;
      fog     = (p < 8) ? fog_pick[p] : $urandom_range(0, 511);
      write_reg(REG_FOG_LEVEL, fog);
      write_reg(REG_THREE_CHANNEL, (p < 8) ? p % 2 : $urandom_range(0, 1));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
        end else begin
          gap = 0;
        end
        burst_left = burst_left - 1;
        if ($urandom_range(0, 299) == 0) begin
          wait_drained();
        end
        push_pixel(random_pixel(), gap);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
